[hdl/glo_pkg.sv]
// ----------------------------------------------------------------------------
// glo_pkg: shared types and constants of the grid line overlay
// Field widths, register indexes, the queued item and the setup sequencer
// state.
// ----------------------------------------------------------------------------
package glo_pkg;

  // Field and register widths
  localparam int PIX_W      = 24;
  localparam int DIM_W      = 13;
  localparam int THK_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_PARTS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PARTS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_THICKNESS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COLOR     = 3'd5;

  // Classified item handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             paint;
    logic             frame_end;
  } glo_item_t;

  // Setup sequencer: part sizes, line limits, band counters
  typedef enum logic [2:0] {
    SEQ_DIV_PW,
    SEQ_DIV_PH,
    SEQ_MUL,
    SEQ_DIV_C0,
    SEQ_DIV_C,
    SEQ_DIV_R0,
    SEQ_DIV_R,
    SEQ_IDLE
  } seq_state_t;

endpackage

[hdl/glo_div.sv]
// ----------------------------------------------------------------------------
// glo_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle while busy, MSB first. A start
// reloads the unit at any time; done pulses for one cycle, set with the last step.
// ----------------------------------------------------------------------------
module glo_div #(
  parameter int DVD_W = 14,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    rem_sh = {rem, quo[DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = rem_sh >= {1'b0, dvs};
  end

  // Step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[hdl/glo_front.sv]
// ----------------------------------------------------------------------------
// glo_front: configuration, setup and pixel classification
// Holds the registers, derives part sizes and band counters with a shared
// divider, tracks column and row, and marks each accepted pixel as line or
// not before it goes into the queue.
// ----------------------------------------------------------------------------
module glo_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [glo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [glo_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              push,
  input  logic [glo_pkg::PIX_W-1:0]         pixel_in,
  output logic                              full,
  output logic                              q_push,
  output glo_pkg::glo_item_t                q_item,
  input  logic                              q_full,
  output logic [glo_pkg::PIX_W-1:0]         line_color
);

  localparam int DIM_W = glo_pkg::DIM_W;
  localparam int THK_W = glo_pkg::THK_W;
  localparam int POS_W = $clog2(MAX_DIM);
  localparam int CW    = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;
  localparam int LIM_W = 2 * DIM_W;
  localparam int CMP_W = LIM_W + 1;

  // Configuration registers
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [DIM_W-1:0] column_parts;
  logic [DIM_W-1:0] row_parts;
  logic [THK_W-1:0] line_thickness;

  // Derived values
  logic [DIM_W-1:0] col_span;
  logic [DIM_W-1:0] row_span;
  logic [LIM_W-1:0] col_limit;
  logic [LIM_W-1:0] row_limit;
  logic [CW-1:0]    col_k0;
  logic [DIM_W-1:0] col_r0;
  logic [CW-1:0]    row_k0;
  logic [DIM_W-1:0] row_r0;

  // Position and band counters
  logic [POS_W-1:0] column_pos;
  logic [POS_W-1:0] row_pos;
  logic [CW-1:0]    col_k;
  logic [DIM_W-1:0] col_r;
  logic [CW-1:0]    row_k;
  logic [DIM_W-1:0] row_r;

  // Sequencer
  glo_pkg::seq_state_t state, state_next;
  logic             started;
  logic             div_state;
  logic             div_start;
  logic             div_done;
  logic [CW-1:0]    div_dvd;
  logic [DIM_W-1:0] div_dvs;
  logic [CW-1:0]    div_quo;
  logic [DIM_W-1:0] div_rem;
  logic             step_done;

  // Effective values and band bounds
  logic [DIM_W-1:0] eff_w, eff_h, eff_c, eff_r;
  logic [DIM_W-1:0] two_half;
  logic [CW-1:0]    band_top;

  // Classification
  logic accept;
  logic last_col, last_row;
  logic col_paint, row_paint;

  // Clamp zero and oversize register values
  always_comb begin
    if (frame_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (32'(frame_width) > MAX_DIM) begin
      eff_w = DIM_W'(MAX_DIM);
    end else begin
      eff_w = frame_width;
    end
    if (frame_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (32'(frame_height) > MAX_DIM) begin
      eff_h = DIM_W'(MAX_DIM);
    end else begin
      eff_h = frame_height;
    end
    eff_c    = (column_parts == '0) ? DIM_W'(1) : column_parts;
    eff_r    = (row_parts == '0) ? DIM_W'(1) : row_parts;
    two_half = {1'b0, line_thickness[THK_W-1:1], 1'b0};
    band_top = CW'(two_half) + CW'(line_thickness);
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= DIM_W'(640);
      frame_height   <= DIM_W'(480);
      column_parts   <= DIM_W'(1);
      row_parts      <= DIM_W'(1);
      line_thickness <= THK_W'(1);
      line_color     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        glo_pkg::REG_FRAME_WIDTH:    frame_width    <= cfg_data[DIM_W-1:0];
        glo_pkg::REG_FRAME_HEIGHT:   frame_height   <= cfg_data[DIM_W-1:0];
        glo_pkg::REG_COLUMN_PARTS:   column_parts   <= cfg_data[DIM_W-1:0];
        glo_pkg::REG_ROW_PARTS:      row_parts      <= cfg_data[DIM_W-1:0];
        glo_pkg::REG_LINE_THICKNESS: line_thickness <= cfg_data[THK_W-1:0];
        glo_pkg::REG_LINE_COLOR:     line_color     <= cfg_data[glo_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared divider
  glo_div #(
    .DVD_W (CW),
    .DVS_W (DIM_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign step_done = started && div_done;

  // Sequencer next state; any write restarts the whole setup
  always_comb begin
    state_next = state;
    if (cfg_wr_en) begin
      state_next = glo_pkg::SEQ_DIV_PW;
    end else begin
      case (state)
        glo_pkg::SEQ_DIV_PW: if (step_done) state_next = glo_pkg::SEQ_DIV_PH;
        glo_pkg::SEQ_DIV_PH: if (step_done) state_next = glo_pkg::SEQ_MUL;
        glo_pkg::SEQ_MUL:    state_next = glo_pkg::SEQ_DIV_C0;
        glo_pkg::SEQ_DIV_C0: if (step_done) state_next = glo_pkg::SEQ_DIV_C;
        glo_pkg::SEQ_DIV_C:  if (step_done) state_next = glo_pkg::SEQ_DIV_R0;
        glo_pkg::SEQ_DIV_R0: if (step_done) state_next = glo_pkg::SEQ_DIV_R;
        glo_pkg::SEQ_DIV_R:  if (step_done) state_next = glo_pkg::SEQ_IDLE;
        glo_pkg::SEQ_IDLE:   state_next = glo_pkg::SEQ_IDLE;
        default:             state_next = glo_pkg::SEQ_DIV_PW;
      endcase
    end
  end

  // Sequencer outputs: divider operands per step
  always_comb begin
    div_state = 1'b1;
    div_dvd   = '0;
    div_dvs   = DIM_W'(1);
    case (state)
      glo_pkg::SEQ_DIV_PW: begin
        div_dvd = CW'(eff_w) + CW'(eff_c) - CW'(1);
        div_dvs = eff_c;
      end
      glo_pkg::SEQ_DIV_PH: begin
        div_dvd = CW'(eff_h) + CW'(eff_r) - CW'(1);
        div_dvs = eff_r;
      end
      glo_pkg::SEQ_DIV_C0: begin
        div_dvd = CW'(two_half);
        div_dvs = col_span;
      end
      glo_pkg::SEQ_DIV_C: begin
        div_dvd = CW'(column_pos) + CW'(two_half);
        div_dvs = col_span;
      end
      glo_pkg::SEQ_DIV_R0: begin
        div_dvd = CW'(two_half);
        div_dvs = row_span;
      end
      glo_pkg::SEQ_DIV_R: begin
        div_dvd = CW'(row_pos) + CW'(two_half);
        div_dvs = row_span;
      end
      default: div_state = 1'b0;
    endcase
    div_start = div_state && !started;
  end

  // Sequencer state, divider launch and result capture
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= glo_pkg::SEQ_DIV_PW;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en || step_done) begin
        started <= 1'b0;
      end else if (div_start) begin
        started <= 1'b1;
      end
    end
    if (step_done) begin
      case (state)
        glo_pkg::SEQ_DIV_PW: col_span <= div_quo[DIM_W-1:0];
        glo_pkg::SEQ_DIV_PH: row_span <= div_quo[DIM_W-1:0];
        glo_pkg::SEQ_DIV_C0: begin
          col_k0 <= div_quo;
          col_r0 <= div_rem;
        end
        glo_pkg::SEQ_DIV_R0: begin
          row_k0 <= div_quo;
          row_r0 <= div_rem;
        end
        default: ;
      endcase
    end
    if (state == glo_pkg::SEQ_MUL) begin
      col_limit <= LIM_W'(eff_c - DIM_W'(1)) * LIM_W'(col_span);
      row_limit <= LIM_W'(eff_r - DIM_W'(1)) * LIM_W'(row_span);
    end
  end

  assign full   = (state != glo_pkg::SEQ_IDLE) || q_full;
  assign accept = push && !full;

  // Band test: k = (pos + 2h) / part, r its remainder; inside while r < 2h + t,
  // past the last division compare against its fixed limit
  always_comb begin
    last_col = CW'(column_pos) >= CW'(eff_w) - CW'(1);
    last_row = CW'(row_pos) >= CW'(eff_h) - CW'(1);
    col_paint = (eff_c != DIM_W'(1)) && (col_k != '0) &&
                ((col_k <= CW'(eff_c) - CW'(1)) ?
                 (CW'(col_r) + CW'(1) <= band_top) :
                 (CMP_W'(col_limit) + CMP_W'(line_thickness) >=
                  CMP_W'(column_pos) + CMP_W'(1)));
    row_paint = (eff_r != DIM_W'(1)) && (row_k != '0) &&
                ((row_k <= CW'(eff_r) - CW'(1)) ?
                 (CW'(row_r) + CW'(1) <= band_top) :
                 (CMP_W'(row_limit) + CMP_W'(line_thickness) >=
                  CMP_W'(row_pos) + CMP_W'(1)));
    q_push           = accept;
    q_item.pixel     = pixel_in;
    q_item.paint     = col_paint || row_paint;
    q_item.frame_end = last_col && last_row;
  end

  // Position and band counters; setup reloads the band counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_pos <= '0;
        row_pos    <= last_row ? '0 : row_pos + POS_W'(1);
      end else begin
        column_pos <= column_pos + POS_W'(1);
      end
    end
    if (step_done && state == glo_pkg::SEQ_DIV_C) begin
      col_k <= div_quo;
      col_r <= div_rem;
    end else if (accept) begin
      if (last_col) begin
        col_k <= col_k0;
        col_r <= col_r0;
      end else if (col_r + DIM_W'(1) == col_span) begin
        col_k <= col_k + CW'(1);
        col_r <= '0;
      end else begin
        col_r <= col_r + DIM_W'(1);
      end
    end
    if (step_done && state == glo_pkg::SEQ_DIV_R) begin
      row_k <= div_quo;
      row_r <= div_rem;
    end else if (accept && last_col) begin
      if (last_row) begin
        row_k <= row_k0;
        row_r <= row_r0;
      end else if (row_r + DIM_W'(1) == row_span) begin
        row_k <= row_k + CW'(1);
        row_r <= '0;
      end else begin
        row_r <= row_r + DIM_W'(1);
      end
    end
  end

endmodule

[hdl/glo_queue.sv]
// ----------------------------------------------------------------------------
// glo_queue: short item queue between front and back
// Register-based FIFO, simultaneous push and pop in one cycle.
// ----------------------------------------------------------------------------
module glo_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  glo_pkg::glo_item_t wr_item,
  output logic               q_full,
  input  logic               rd,
  output glo_pkg::glo_item_t rd_item,
  output logic               q_empty
);

  localparam int DEPTH = glo_pkg::QUEUE_DEPTH;
  localparam int PTR_W = glo_pkg::QPTR_W;
  localparam int CNT_W = PTR_W + 1;

  glo_pkg::glo_item_t slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign q_full  = count == CNT_W'(DEPTH);
  assign q_empty = count == '0;
  assign rd_item = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Item storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

[hdl/glo_back.sv]
// ----------------------------------------------------------------------------
// glo_back: line paint and result register
// Pulls classified items from the queue, substitutes the line color on
// line pixels and holds the result until it is popped.
// ----------------------------------------------------------------------------
module glo_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  glo_pkg::glo_item_t        q_item,
  output logic                      q_pop,
  input  logic [glo_pkg::PIX_W-1:0] line_color,
  output logic [glo_pkg::PIX_W-1:0] pixel_out,
  output logic                      frame_end,
  output logic                      empty,
  input  logic                      pop
);

  logic out_valid;
  logic load;

  // Refill the result register when it is free or being taken
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      pixel_out <= q_item.paint ? line_color : q_item.pixel;
      frame_end <= q_item.frame_end;
    end
  end

endmodule

[hdl/grid_line_overlay.sv]
// ----------------------------------------------------------------------------
// grid_line_overlay: grid divider lines painted over a raster pixel stream
// Front classifies each pixel by column and row, a short queue decouples it
// from the back, which applies the line color and presents the result.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   input    | push / full          | pixel_in
//   result   | empty / pop          | pixel_out, frame_end
//   config   | cfg_wr_en            | cfg_index, cfg_data
//
// One pixel per clock sustained while results are popped and setup is idle;
// a pushed pixel is written into the queue, then into the result register.
// After reset and every register write the front runs its setup through one
// shared bit-serial divider (six divisions and one multiply), full held high.
// Either side may stall; the queue and result register absorb it.
// ----------------------------------------------------------------------------
module grid_line_overlay #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [glo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [glo_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [glo_pkg::PIX_W-1:0]      pixel_in,
  output logic                           empty,
  input  logic                           pop,
  output logic [glo_pkg::PIX_W-1:0]      pixel_out,
  output logic                           frame_end
);

  logic                      q_push;
  logic                      q_pop;
  logic                      q_full;
  logic                      q_empty;
  glo_pkg::glo_item_t        q_in;
  glo_pkg::glo_item_t        q_out;
  logic [glo_pkg::PIX_W-1:0] line_color;

  // Front: registers, setup, classification
  glo_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .pixel_in   (pixel_in),
    .full       (full),
    .q_push     (q_push),
    .q_item     (q_in),
    .q_full     (q_full),
    .line_color (line_color)
  );

  // Queue between front and back
  glo_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_item (q_in),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_item (q_out),
    .q_empty (q_empty)
  );

  // Back: paint and result register
  glo_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .line_color (line_color),
    .pixel_out  (pixel_out),
    .frame_end  (frame_end),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

[test/tb_grid_line_overlay.sv]
// ----------------------------------------------------------------------------
// tb_grid_line_overlay: self-checking testbench of the grid line overlay
// A clocked driver pushes pixels from a pending queue in random bursts, a
// clocked monitor pops results on its own stall pattern and checks each one
// against a local overlay predictor. Setups change only while the block is
// idle; a short directed part is followed by random setups and pixels.
// ----------------------------------------------------------------------------
module tb_grid_line_overlay;

  localparam int MAX_DIM   = 4096;
  localparam int N_ITEMS   = 1250;
  localparam int MAX_SHOWN = 100;

  localparam int PIX_W      = glo_pkg::PIX_W;
  localparam int DIM_W      = glo_pkg::DIM_W;
  localparam int THK_W      = glo_pkg::THK_W;
  localparam int CFG_IDX_W  = glo_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = glo_pkg::CFG_DATA_W;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } overlay_px_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  push      = 1'b0;
  logic                  full;
  logic [PIX_W-1:0]      pixel_in  = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  logic [PIX_W-1:0]      pixel_out;
  logic                  frame_end;

  grid_line_overlay #(.MAX_DIM(MAX_DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .pixel_in  (pixel_in),
    .empty     (empty),
    .pop       (pop),
    .pixel_out (pixel_out),
    .frame_end (frame_end)
  );

  always #4 clk = ~clk;

  // Pixels waiting to be pushed, and overlaid pixels waiting to come out
  logic [PIX_W-1:0] pending_pixels[$];
  overlay_px_t      overlay_expected[$];

  // Shadow registers and overlay state
  int unsigned frame_w   = 640;
  int unsigned frame_h   = 480;
  int unsigned col_parts = 1;
  int unsigned row_parts = 1;
  int unsigned thickness = 1;
  logic [PIX_W-1:0] line_rgb = '0;
  int unsigned part_w, part_h;
  int unsigned col_pos   = 0;
  int unsigned row_pos   = 0;

  // Run statistics
  int errors          = 0;
  int items_queued    = 0;
  int results_checked = 0;
  int frames_ended    = 0;
  int painted_px      = 0;
  int setups          = 0;
  int full_holds      = 0;
  bit long_stall_done = 1'b0;

  function automatic int unsigned eff_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned eff_parts(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void derive_parts();
    part_w = (eff_dim(frame_w) + eff_parts(col_parts) - 1) / eff_parts(col_parts);
    part_h = (eff_dim(frame_h) + eff_parts(row_parts) - 1) / eff_parts(row_parts);
  endfunction

  // Position p lies in the band around some division i*s, i in 1..n-1
  function automatic bit in_band(input longint unsigned p, input longint unsigned s,
                                 input longint unsigned n);
    longint unsigned t, k;
    t = thickness;
    if (s == 0 || n < 2) return 1'b0;
    k = (p + 2 * (t / 2)) / s;
    if (k > n - 1) k = n - 1;
    if (k < 1) return 1'b0;
    return (k * s + t >= p + 1);
  endfunction

  // Overlay one accepted pixel and advance the raster position
  function automatic void paint_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w, h;
    bit last_col, last_row, on_grid;
    overlay_px_t res;
    w = eff_dim(frame_w);
    h = eff_dim(frame_h);
    last_col = (col_pos >= w - 1);
    last_row = (row_pos >= h - 1);
    on_grid  = in_band(col_pos, part_w, eff_parts(col_parts)) ||
               in_band(row_pos, part_h, eff_parts(row_parts));
    res.pixel     = on_grid ? line_rgb : pix;
    res.frame_end = last_col && last_row;
    overlay_expected.push_back(res);
    painted_px   += on_grid;
    frames_ended += res.frame_end;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of pushes with random gaps
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : pixel_driver
    bit accepted;
    accepted = !rst && push && !full;
    if (!rst && push && full) full_holds++;
    if (accepted) begin
      paint_pixel(pixel_in);
      void'(pending_pixels.pop_front());
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                 : $urandom_range(0, 3);
      end
    end else if (gap_left > 0) begin
      gap_left--;
    end
    if (!rst && pending_pixels.size() > 0 && gap_left == 0) begin
      push     <= 1'b1;
      pixel_in <= pending_pixels[0];
    end else begin
      push <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each popped result, pops on a pattern of its own
  // --------------------------------------------------------------------------
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int long_hold    = 0;
  bit rx_toggle    = 1'b0;

  always @(posedge clk) begin : result_check
    overlay_px_t want;
    bit next_pop;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (overlay_expected.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: result with none pending: pixel_out=%06h frame_end=%b",
                     $time, pixel_out, frame_end);
        end else begin
          want = overlay_expected.pop_front();
          results_checked++;
          if (pixel_out !== want.pixel) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("%0t: pixel_out mismatch: expected %06h, got %06h",
                       $time, want.pixel, pixel_out);
          end
          if (frame_end !== want.frame_end) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("%0t: frame_end mismatch: expected %b, got %b",
                       $time, want.frame_end, frame_end);
          end
        end
      end

      // one long hold-off while the sender still has plenty to offer
      if (!long_stall_done && results_checked >= 300 && pending_pixels.size() > 20) begin
        long_stall_done = 1'b1;
        long_hold = 150;
      end

      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(10, 80);
      end else begin
        rx_mode_left--;
      end
      rx_toggle = ~rx_toggle;

      if (long_hold > 0) begin
        long_hold--;
        next_pop = 1'b0;
      end else begin
        case (rx_mode)
          0:       next_pop = 1'b1;
          1:       next_pop = ($urandom_range(0, 3) != 0);
          2:       next_pop = ($urandom_range(0, 3) == 0);
          default: next_pop = rx_toggle;
        endcase
      end
      pop <= next_pop;
    end
  end

  // --------------------------------------------------------------------------
  // Register writes, only with the block idle; waits out the setup pass
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      glo_pkg::REG_FRAME_WIDTH:    frame_w   = val[DIM_W-1:0];
      glo_pkg::REG_FRAME_HEIGHT:   frame_h   = val[DIM_W-1:0];
      glo_pkg::REG_COLUMN_PARTS:   col_parts = val[DIM_W-1:0];
      glo_pkg::REG_ROW_PARTS:      row_parts = val[DIM_W-1:0];
      glo_pkg::REG_LINE_THICKNESS: thickness = val[THK_W-1:0];
      glo_pkg::REG_LINE_COLOR:     line_rgb  = val[PIX_W-1:0];
      default: ;
    endcase
    derive_parts();
    repeat (2) @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic setup_grid(input int unsigned w, input int unsigned h,
                            input int unsigned c, input int unsigned r,
                            input int unsigned t, input logic [PIX_W-1:0] rgb);
    write_reg(glo_pkg::REG_FRAME_WIDTH,    {11'($urandom), DIM_W'(w)});
    write_reg(glo_pkg::REG_FRAME_HEIGHT,   {11'($urandom), DIM_W'(h)});
    write_reg(glo_pkg::REG_COLUMN_PARTS,   {11'($urandom), DIM_W'(c)});
    write_reg(glo_pkg::REG_ROW_PARTS,      {11'($urandom), DIM_W'(r)});
    write_reg(glo_pkg::REG_LINE_THICKNESS, {12'($urandom), THK_W'(t)});
    write_reg(glo_pkg::REG_LINE_COLOR,     rgb);
    setups++;
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || overlay_expected.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  task automatic queue_pixels(input int n);
    int k;
    logic [PIX_W-1:0] v;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = '1;
        default: v = PIX_W'($urandom);
      endcase
      pending_pixels.push_back(v);
      items_queued++;
    end
  endtask

  // Size draw: mostly small, sometimes zero, the maximum or oversize
  function automatic int unsigned pick_size(input int unsigned common_max);
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return MAX_DIM;
      2:       return $urandom_range(MAX_DIM + 1, 8191);
      3:       return $urandom_range(1, 8191);
      default: return $urandom_range(1, common_max);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int n, t;
    derive_parts();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    while (full) @(posedge clk);

    // reset setup: no dividers, pixels pass through
    pending_pixels.push_back(24'h000000);
    pending_pixels.push_back(24'hFFFFFF);
    items_queued += 2;
    wait_drained();

    // small 4x3 frame, one divider each way, a whole frame and its end
    setup_grid(4, 3, 2, 2, 1, 24'hA5A5A5);
    for (n = 0; n < 12; n++) begin
      pending_pixels.push_back(n[0] ? 24'h5A5A5A : 24'hFFFFFF);
      items_queued++;
    end
    wait_drained();

    // zero sizes and counts act as one; zero thickness paints nothing
    setup_grid(0, 0, 0, 0, 0, 24'hFFFFFF);
    pending_pixels.push_back(24'h123456);
    pending_pixels.push_back(24'hEDCBA9);
    items_queued += 2;
    wait_drained();

    // oversize width clamps, widest band covers all; spare indexes ignored
    setup_grid(8191, 1, MAX_DIM, 1, 4095, 24'h000000);
    write_reg(REG_SPARE_6, 24'hFFFFFF);
    write_reg(REG_SPARE_7, 24'h5A5A5A);
    pending_pixels.push_back(24'hFFFFFF);
    pending_pixels.push_back(24'h800001);
    pending_pixels.push_back(24'h7FFFFE);
    items_queued += 3;
    wait_drained();

    // random setups, each taking effect wherever the raster position stands
    while (items_queued < N_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       t = 0;
        1:       t = 4095;
        2:       t = $urandom_range(0, 4095);
        default: t = $urandom_range(0, 6);
      endcase
      setup_grid(pick_size(24), pick_size(24), pick_size(8), pick_size(8), t,
                 PIX_W'($urandom));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, CFG_DATA_W'($urandom));
      queue_pixels($urandom_range(30, 90));
      // sometimes the sender pauses until everything has come back
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        queue_pixels($urandom_range(10, 40));
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d pixels over %0d setups: %0d frame ends, %0d painted pixels.",
             results_checked, setups, frames_ended, painted_px);
    $display("Input held off by a full block for %0d cycles; long result stall %s.",
             full_holds, long_stall_done ? "done" : "not reached");
    if (errors == 0) begin
      $display("tb_grid_line_overlay: PASS");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("tb_grid_line_overlay: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2000000;
    $display("Timeout with %0d pixels waiting and %0d results outstanding",
             pending_pixels.size(), overlay_expected.size());
    $display("tb_grid_line_overlay: FAIL");
    $finish;
  end

endmodule
